>>> hdl/lfu_pkg.sv
// Shared types and constants for the LFU table cache directory.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package lfu_pkg;

  localparam int TAG_W     = 63;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 4;

  localparam logic [CNT_W-1:0] CNT_TOP = 32'hffff_ffff;
  localparam logic [CNT_W-1:0] CNT_ONE = 32'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_AGE_START,
    ST_AGE,
    ST_MISS,
    ST_DONE
  } lfu_state_t;

  // Write strobes into the way store
  typedef struct packed {
    logic tag_we;
    logic cnt_we;
  } lfu_wr_ctl_t;

endpackage

`default_nettype wire

>>> hdl/lfu_in_if.sv
// Lookup request channel: valid/ready handshake carrying one table tag.
// Depends on lfu_pkg for the tag width.
`default_nettype none

interface lfu_in_if;
  import lfu_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] table_tag;

  modport source (output valid, output table_tag, input ready);
  modport sink   (input valid, input table_tag, output ready);
endinterface

`default_nettype wire

>>> hdl/lfu_out_if.sv
// Lookup result channel: valid/ready handshake carrying hit, way and evicted tag.
// Depends on lfu_pkg for the field widths.
`default_nettype none

interface lfu_out_if;
  import lfu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [TAG_W-1:0]     evicted_tag;

  modport source (output valid, output hit, output way, output evicted_tag, input ready);
  modport sink   (input valid, input hit, input way, input evicted_tag, output ready);
endinterface

`default_nettype wire

>>> hdl/lfu_way_store.sv
// Tag and use-count memories for all ways, one write and one registered read per cycle.
// Per-way valid bits make a never-written way read as empty tag and zero count.
// Depends on lfu_pkg.
`default_nettype none

module lfu_way_store import lfu_pkg::*; #(
  parameter int WAYS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [$clog2(WAYS)-1:0]  rd_addr,
  input  wire lfu_wr_ctl_t              wr_ctl,
  input  wire logic [$clog2(WAYS)-1:0]  wr_addr,
  input  wire logic [TAG_W-1:0]         wr_tag,
  input  wire logic [CNT_W-1:0]         wr_cnt,
  output logic      [TAG_W-1:0]         rd_tag,
  output logic      [CNT_W-1:0]         rd_cnt
);

  logic [TAG_W-1:0] tag_mem [WAYS];
  logic [CNT_W-1:0] cnt_mem [WAYS];
  logic [WAYS-1:0]  valid_r;
  logic [TAG_W-1:0] tag_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;
  logic             vld_rd_r;

  // Mark a way as holding a tag once it has been written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ctl.tag_we) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Write ports
  always_ff @(posedge clk) begin
    if (wr_ctl.tag_we) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (wr_ctl.cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    tag_rd_r <= tag_mem[rd_addr];
    cnt_rd_r <= cnt_mem[rd_addr];
    vld_rd_r <= valid_r[rd_addr];
  end

  // Empty ways read as tag zero, count zero
  assign rd_tag = vld_rd_r ? tag_rd_r : '0;
  assign rd_cnt = vld_rd_r ? cnt_rd_r : '0;

endmodule

`default_nettype wire

>>> hdl/lfu_table_cache_policy_core.sv
// Top level of the LFU table cache directory: request sequencer, way scan and aging.
// Depends on lfu_pkg, lfu_in_if, lfu_out_if and lfu_way_store.
//
//   Channel   Dir   Handshake      Payload
//   in_req    in    valid/ready    table_tag[62:0]
//   out_rsp   out   valid/ready    hit, way[3:0], evicted_tag[62:0]
//
// One request at a time; the way memories are scanned one way per cycle through
// a single read port and a single comparator. A hit whose incremented count
// saturates also halves all counts. A zero tag answers with no lookup and an
// empty result. in_req.ready is high only in the idle state.
// A finished result sits in the output register; a stalled out_rsp holds the
// sequencer in its done state. Synchronous active-low reset empties all ways.
`default_nettype none

module lfu_table_cache_policy_core import lfu_pkg::*; #(
  parameter int WAYS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lfu_in_if.sink     in_req,
  lfu_out_if.source  out_rsp
);

  localparam int IDX_W = $clog2(WAYS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAYS - 1);

  lfu_state_t       state_r, state_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [TAG_W-1:0] pick_tag_r, pick_tag_nxt;
  logic [CNT_W-1:0] min_r, min_nxt;
  logic [CNT_W-1:0] cnt_inc_r, cnt_inc_nxt;
  logic             hit_r, hit_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [WAY_OUT_W-1:0] out_way_r;
  logic [TAG_W-1:0]     out_evict_r;
  logic                 out_load;

  logic [IDX_W-1:0] rd_addr;
  lfu_wr_ctl_t      wr_ctl;
  logic [IDX_W-1:0] wr_addr;
  logic [TAG_W-1:0] wr_tag;
  logic [CNT_W-1:0] wr_cnt;
  logic [TAG_W-1:0] rd_tag;
  logic [CNT_W-1:0] rd_cnt;
  logic             match;

  lfu_way_store #(.WAYS(WAYS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_tag  (wr_tag),
    .wr_cnt  (wr_cnt),
    .rd_tag  (rd_tag),
    .rd_cnt  (rd_cnt)
  );

  assign match = (rd_tag == tag_r);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    tag_r      <= tag_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    pick_r     <= pick_nxt;
    pick_tag_r <= pick_tag_nxt;
    min_r      <= min_nxt;
    cnt_inc_r  <= cnt_inc_nxt;
    hit_r      <= hit_nxt;
  end

  // Sequencer: next state, memory access and scan bookkeeping
  always_comb begin
    state_nxt    = state_r;
    tag_nxt      = tag_r;
    cmp_idx_nxt  = cmp_idx_r;
    pick_nxt     = pick_r;
    pick_tag_nxt = pick_tag_r;
    min_nxt      = min_r;
    cnt_inc_nxt  = cnt_inc_r;
    hit_nxt      = hit_r;
    rd_addr      = cmp_idx_r + 1'b1;
    wr_ctl       = '0;
    wr_addr      = pick_r;
    wr_tag       = tag_r;
    wr_cnt       = cnt_inc_r;
    out_load     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          tag_nxt = in_req.table_tag;
          if (in_req.table_tag == '0) begin
            // Zero tag: no lookup, empty result
            hit_nxt      = 1'b0;
            pick_nxt     = '0;
            pick_tag_nxt = '0;
            state_nxt    = ST_DONE;
          end else begin
            rd_addr     = '0;
            cmp_idx_nxt = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        cmp_idx_nxt = rd_addr;
        if (match) begin
          pick_nxt    = cmp_idx_r;
          cnt_inc_nxt = rd_cnt + 1'b1;
          hit_nxt     = 1'b1;
          state_nxt   = ST_HIT;
        end else begin
          // Track the lowest-numbered way with the strictly smallest count
          if (cmp_idx_r == '0 || rd_cnt < min_r) begin
            min_nxt      = rd_cnt;
            pick_nxt     = cmp_idx_r;
            pick_tag_nxt = rd_tag;
          end
          if (cmp_idx_r == LAST_IDX) begin
            hit_nxt   = 1'b0;
            state_nxt = ST_MISS;
          end
        end
      end

      ST_HIT: begin
        wr_ctl.cnt_we = 1'b1;
        state_nxt     = (cnt_inc_r == CNT_TOP) ? ST_AGE_START : ST_DONE;
      end

      ST_AGE_START: begin
        // Issue the first read after the hit write has landed
        rd_addr     = '0;
        cmp_idx_nxt = '0;
        state_nxt   = ST_AGE;
      end

      ST_AGE: begin
        // Halve one count per cycle while reading the next
        wr_ctl.cnt_we = 1'b1;
        wr_addr       = cmp_idx_r;
        wr_cnt        = rd_cnt >> 1;
        cmp_idx_nxt   = rd_addr;
        if (cmp_idx_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end
      end

      ST_MISS: begin
        wr_ctl.tag_we = 1'b1;
        wr_ctl.cnt_we = 1'b1;
        wr_cnt        = CNT_ONE;
        state_nxt     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: hold until the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r   <= hit_r;
      out_way_r   <= WAY_OUT_W'(pick_r);
      out_evict_r <= hit_r ? '0 : pick_tag_r;
    end
  end

  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.hit         = out_hit_r;
  assign out_rsp.way         = out_way_r;
  assign out_rsp.evicted_tag = out_evict_r;

endmodule

`default_nettype wire
